FILE: rtl/slpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpl_pkg: shared definitions for the slot pool linked list unit
// Field widths, operation and status codes, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package slpl_pkg;

  // Pool size default and fixed field widths
  localparam int SLOTS_DEF  = 128;
  localparam int SLOT_W     = 7;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 8;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 3;

  // Operation codes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FOLLOW  = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_HEAD     = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  // Controller to datapath: one step strobe each
  typedef struct packed {
    logic accept;      // take the input beat, start the link read
    logic clr_wr;      // write one entry of the clearing pass
    logic alloc_link;  // pop free top, link it behind the tail
    logic alloc_tail;  // terminate the new slot, move the tail
    logic rel_check;   // check busy bit, unlink from neighbors
    logic rel_free;    // push the released slot on the free list
    logic fol_res;     // form the follow result
    logic out_load;    // move the result into the output register
  } slpl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;          // opcode on the input channel
    logic imm_done;    // input beat completes without memory work
    logic rd_busy;     // busy bit read for the current slot
    logic clr_last;    // clearing pass is at its last entry
    logic out_free;    // output register can take a result this cycle
  } slpl_stat_t;

endpackage
`default_nettype wire

FILE: rtl/slot_pool_linked_list_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slot_pool_linked_list_unit: slot pool with in-use list and free list
// Allocates, releases and follows slots of a fixed pool kept as a doubly
// linked in-use list headed by slot 0 and a last-in first-out free list.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all SLOTS entries (128 by default)
// with in_tready low, then takes one operation at a time. An allocate steps
// through the link and tail states, a release of an in-use slot through the
// check and free states, follow and release of a free slot through a single
// work state, and a rejected operation (pool full, head slot, slot out of range)
// or opcode 3 goes straight to the emit state; the link memories are read once
// at acceptance and written at one address per memory per cycle. Each beat
// gives exactly one result beat, held in an output register, so a new
// operation is accepted while an earlier result still waits; the result of
// that new operation holds in_tready low until the register frees.
module slot_pool_linked_list_unit
  import slpl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // slot[6:0], zero[7]
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // opcode[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // result_slot[6:0], used_count[14:7], zero[15]
  output logic [OUT_USER_W-1:0]      out_tuser   // has_slot[0], status[2:1]
);

  slpl_cmd_t  cmd;
  slpl_stat_t stat;

  // Sequencer
  slpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Link memories and registers
  slpl_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

FILE: rtl/slpl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpl_ctrl: operation sequencer
// One-hot state machine that runs the clearing pass after reset and steps
// each accepted operation through its memory read and write cycles.
// ----------------------------------------------------------------------------
module slpl_ctrl
  import slpl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire slpl_stat_t stat,
  output slpl_cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_CLR        = 8'b0000_0001,
    S_IDLE       = 8'b0000_0010,
    S_ALLOC_LINK = 8'b0000_0100,
    S_ALLOC_TAIL = 8'b0000_1000,
    S_REL_CHK    = 8'b0001_0000,
    S_REL_FREE   = 8'b0010_0000,
    S_FOL_RES    = 8'b0100_0000,
    S_EMIT       = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt, start_st;
  logic   accept;

  // Pick the first work state for a new beat
  always_comb begin
    if (stat.imm_done) begin
      start_st = S_EMIT;
    end else begin
      case (stat.op)
        OP_ALLOC:   start_st = S_ALLOC_LINK;
        OP_RELEASE: start_st = S_REL_CHK;
        OP_FOLLOW:  start_st = S_FOL_RES;
        default:    start_st = S_EMIT;
      endcase
    end
  end

  // Accept while idle, or while the last result drains this cycle
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_EMIT) && stat.out_free);
  assign accept    = in_tvalid && in_tready;

  // Decode steps and next state
  always_comb begin
    cmd        = '0;
    cmd.accept = accept;
    state_nxt  = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = start_st;
      end
      S_ALLOC_LINK: begin
        cmd.alloc_link = 1'b1;
        state_nxt      = S_ALLOC_TAIL;
      end
      S_ALLOC_TAIL: begin
        cmd.alloc_tail = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_REL_CHK: begin
        cmd.rel_check = 1'b1;
        state_nxt     = stat.rd_busy ? S_REL_FREE : S_EMIT;
      end
      S_REL_FREE: begin
        cmd.rel_free = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_FOL_RES: begin
        cmd.fol_res = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        cmd.out_load = stat.out_free;
        if (accept) begin
          state_nxt = start_st;
        end else if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/slpl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slpl_dpath: link memories and list registers
// Holds the back link, fore link and busy memories, the free top, tail and
// count registers, the result register and the output register.
// ----------------------------------------------------------------------------
module slpl_dpath
  import slpl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire slpl_cmd_t             cmd,
  output slpl_stat_t                 stat,
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam int XW = (LW > SLOT_W) ? LW : SLOT_W;
  localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

  // Link memories
  logic [LW-1:0] back_mem [SLOTS];
  logic [LW-1:0] fore_mem [SLOTS];
  logic          busy_mem [SLOTS];

  logic [LW-1:0] back_rd_r, fore_rd_r;
  logic          busy_rd_r;

  // List registers
  logic [LW-1:0] free_top_r, tail_r, total_r;
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] addr_r;

  // Result and output registers
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_has_r, res_has_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              res_load;
  logic              out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_has_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_count_r;

  // Input beat decode
  op_t           in_op;
  logic [SLOT_W-1:0] in_slot;
  logic [XW-1:0] slot_ext;
  logic          slot_ok;
  logic [AW-1:0] rd_addr;
  logic          imm_done;
  status_t       imm_status;

  assign in_op    = op_t'(in_tuser);
  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign slot_ext = XW'(in_slot);
  assign slot_ok  = slot_ext < XW'(SLOTS);
  assign rd_addr  = (in_op == OP_ALLOC) ? free_top_r[AW-1:0] : slot_ext[AW-1:0];

  // Flag operations that finish at once
  always_comb begin
    imm_done   = 1'b0;
    imm_status = ST_OK;
    case (in_op)
      OP_ALLOC: begin
        if (free_top_r == LINK_NONE) begin
          imm_done   = 1'b1;
          imm_status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (in_slot == '0) begin
          imm_done   = 1'b1;
          imm_status = ST_HEAD;
        end else if (!slot_ok) begin
          imm_done   = 1'b1;
          imm_status = ST_NOT_USED;
        end
      end
      OP_FOLLOW: begin
        if (!slot_ok) begin
          imm_done   = 1'b1;
          imm_status = ST_NOT_USED;
        end
      end
      default: begin
        imm_done   = 1'b1;
        imm_status = ST_OK;
      end
    endcase
  end

  // Neighbor checks on the links read for a release
  logic rel_is_tail, nx_ok, pv_ok, fol_ok;
  assign rel_is_tail = (LW'(addr_r) == tail_r);
  assign nx_ok       = fore_rd_r < LINK_NONE;
  assign pv_ok       = back_rd_r < LINK_NONE;
  assign fol_ok      = fore_rd_r < LINK_NONE;

  // Clearing pass values
  logic [LW-1:0] back_clr;
  assign back_clr = ((clr_idx_r == '0) || (clr_idx_r == AW'(SLOTS - 1))) ? LINK_NONE :
                    (LW'(clr_idx_r) + LW'(1));

  // Back link write port
  logic          back_we;
  logic [AW-1:0] back_wa;
  logic [LW-1:0] back_wd;
  always_comb begin
    back_we = 1'b0;
    back_wa = clr_idx_r;
    back_wd = back_clr;
    if (cmd.clr_wr) begin
      back_we = 1'b1;
    end else if (cmd.alloc_link) begin
      back_we = 1'b1;
      back_wa = addr_r;
      back_wd = tail_r;
    end else if (cmd.rel_check && busy_rd_r && !rel_is_tail && nx_ok) begin
      back_we = 1'b1;
      back_wa = fore_rd_r[AW-1:0];
      back_wd = back_rd_r;
    end else if (cmd.rel_free) begin
      back_we = 1'b1;
      back_wa = addr_r;
      back_wd = free_top_r;
    end
  end

  // Fore link write port
  logic          fore_we;
  logic [AW-1:0] fore_wa;
  logic [LW-1:0] fore_wd;
  always_comb begin
    fore_we = 1'b0;
    fore_wa = clr_idx_r;
    fore_wd = LINK_NONE;
    if (cmd.clr_wr) begin
      fore_we = 1'b1;
    end else if (cmd.alloc_link) begin
      fore_we = tail_r < LINK_NONE;
      fore_wa = tail_r[AW-1:0];
      fore_wd = LW'(addr_r);
    end else if (cmd.alloc_tail) begin
      fore_we = 1'b1;
      fore_wa = addr_r;
    end else if (cmd.rel_check && busy_rd_r && pv_ok) begin
      fore_we = 1'b1;
      fore_wa = back_rd_r[AW-1:0];
      fore_wd = fore_rd_r;
    end
  end

  // Busy bit write port
  logic          busy_we;
  logic [AW-1:0] busy_wa;
  logic          busy_wd;
  always_comb begin
    busy_we = 1'b0;
    busy_wa = clr_idx_r;
    busy_wd = (clr_idx_r == '0);
    if (cmd.clr_wr) begin
      busy_we = 1'b1;
    end else if (cmd.alloc_link) begin
      busy_we = 1'b1;
      busy_wa = addr_r;
      busy_wd = 1'b1;
    end else if (cmd.rel_free) begin
      busy_we = 1'b1;
      busy_wa = addr_r;
      busy_wd = 1'b0;
    end
  end

  // Write and read the memories
  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_wa] <= back_wd;
    if (fore_we) fore_mem[fore_wa] <= fore_wd;
    if (busy_we) busy_mem[busy_wa] <= busy_wd;
    if (cmd.accept) begin
      back_rd_r <= back_mem[rd_addr];
      fore_rd_r <= fore_mem[rd_addr];
      busy_rd_r <= busy_mem[rd_addr];
    end
  end

  // Form the next result
  always_comb begin
    res_load       = 1'b0;
    res_slot_nxt   = '0;
    res_has_nxt    = 1'b0;
    res_status_nxt = ST_OK;
    if (cmd.accept) begin
      res_load       = 1'b1;
      res_status_nxt = imm_status;
    end else if (cmd.alloc_tail) begin
      res_load     = 1'b1;
      res_slot_nxt = SLOT_W'(addr_r);
      res_has_nxt  = 1'b1;
    end else if (cmd.rel_check) begin
      res_load       = !busy_rd_r;
      res_status_nxt = ST_NOT_USED;
    end else if (cmd.rel_free) begin
      res_load = 1'b1;
    end else if (cmd.fol_res) begin
      res_load     = 1'b1;
      res_slot_nxt = fol_ok ? SLOT_W'(fore_rd_r) : '0;
      res_has_nxt  = fol_ok;
    end
  end

  // Advance list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r  <= LW'(1);
      tail_r      <= '0;
      total_r     <= LW'(1);
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + AW'(1);
      if (cmd.alloc_link) free_top_r <= back_rd_r;
      if (cmd.alloc_tail) begin
        tail_r  <= LW'(addr_r);
        total_r <= total_r + LW'(1);
      end
      if (cmd.rel_check && busy_rd_r && rel_is_tail) tail_r <= back_rd_r;
      if (cmd.rel_free) begin
        free_top_r <= LW'(addr_r);
        total_r    <= total_r - LW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (cmd.accept) addr_r <= rd_addr;
    if (res_load) begin
      res_slot_r   <= res_slot_nxt;
      res_has_r    <= res_has_nxt;
      res_status_r <= res_status_nxt;
    end
    if (cmd.out_load) begin
      out_slot_r   <= res_slot_r;
      out_has_r    <= res_has_r;
      out_status_r <= res_status_r;
      out_count_r  <= CNT_W'(total_r);
    end
  end

  // Status to the controller
  assign stat.op       = in_op;
  assign stat.imm_done = imm_done;
  assign stat.rd_busy  = busy_rd_r;
  assign stat.clr_last = (clr_idx_r == AW'(SLOTS - 1));
  assign stat.out_free = !out_valid_r || out_tready;

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - CNT_W - SLOT_W){1'b0}}, out_count_r, out_slot_r};
  assign out_tuser  = {out_status_r, out_has_r};

`ifndef ASSERT_OFF
  // Free list is empty exactly when every slot is in use; during an allocation the
  // count moves in the tail step, after the free top has moved in the link step
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.alloc_tail |-> ((free_top_r == LINK_NONE) == (total_r == LW'(SLOTS))))
    else $error("free top and use count disagree");

  // Allocation never links a slot into a full pool
  a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_tail |-> (total_r < LW'(SLOTS)))
    else $error("allocation on a full pool");

  // A busy slot that passes the check is pushed on the free list next
  a_rel_then_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rel_check && busy_rd_r) |=> cmd.rel_free)
    else $error("release unlinked but not freed");

  // A new result never overwrites a beat that is still held
  a_load_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && out_valid_r) |-> out_tready)
    else $error("output register overrun");
`endif

endmodule
`default_nettype wire

FILE: tb/slot_pool_linked_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_linked_list_unit_test: self-checking bench for the slot pool unit
// Drives allocate, release, follow and spare-opcode beats with random gaps and
// random output back-pressure. A shadow copy of the pool (links, busy bits,
// free top, tail, count) predicts each result beat. Monitored results are
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module slot_pool_linked_list_unit_test;
  import slpl_pkg::*;

  localparam int                SLOTS     = SLOTS_DEF;
  localparam logic [7:0]        LINK_NONE = 8'(SLOTS);
  localparam logic [OP_W-1:0]   OP_SPARE  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
  } pool_op_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              has;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } pool_res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  // Stimulus and prediction stores
  pool_op_t  op_queue[$];
  pool_res_t due_results[$];
  int        errors = 0;
  logic      in_fired = 1'b0;
  logic      out_fired = 1'b0;

  // Shadow pool state
  logic [7:0] prev_link [SLOTS];
  logic [7:0] next_link [SLOTS];
  logic       in_use    [SLOTS];
  logic [7:0] free_head;
  logic [7:0] tail_slot;
  logic [7:0] live_count;

  // Generator view: free stack top first, live slots in list order
  logic [SLOT_W-1:0] free_stack[$];
  logic [SLOT_W-1:0] live_list[$];
  int                planned = 0;

  slot_pool_linked_list_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow pool and return its result beat
  function automatic pool_res_t pool_step(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s);
    pool_res_t  r;
    logic [7:0] n;
    logic [7:0] pv;
    logic [7:0] nx;
    r = '{slot: '0, has: 1'b0, status: ST_OK, count: '0};
    case (op)
      OP_ALLOC: begin
        n = free_head;
        if (n == LINK_NONE) begin
          r.status = ST_FULL;
        end else begin
          free_head = prev_link[n[SLOT_W-1:0]];
          if (tail_slot != LINK_NONE) next_link[tail_slot[SLOT_W-1:0]] = n;
          prev_link[n[SLOT_W-1:0]] = tail_slot;
          next_link[n[SLOT_W-1:0]] = LINK_NONE;
          in_use[n[SLOT_W-1:0]]    = 1'b1;
          tail_slot    = n;
          live_count++;
          r.slot = n[SLOT_W-1:0];
          r.has  = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (s == '0) begin
          r.status = ST_HEAD;
        end else if (!in_use[s]) begin
          r.status = ST_NOT_USED;
        end else begin
          pv = prev_link[s];
          nx = next_link[s];
          if (8'(s) == tail_slot) tail_slot = pv;
          else if (nx != LINK_NONE) prev_link[nx[SLOT_W-1:0]] = pv;
          if (pv != LINK_NONE) next_link[pv[SLOT_W-1:0]] = nx;
          // successor link is kept, so a walk can step off a freed slot
          prev_link[s] = free_head;
          free_head    = 8'(s);
          in_use[s]    = 1'b0;
          live_count--;
        end
      end
      OP_FOLLOW: begin
        nx = next_link[s];
        if (nx != LINK_NONE) begin
          r.slot = nx[SLOT_W-1:0];
          r.has  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = live_count;
    return r;
  endfunction

  // Queue one beat and keep the generator's view of the pool in step
  task automatic plan(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] s);
    int idx;
    idx = -1;
    op_queue.push_back({op, s});
    planned++;
    if (op == OP_ALLOC && free_stack.size() > 0) begin
      live_list.push_back(free_stack.pop_front());
    end else if (op == OP_RELEASE && s != '0) begin
      foreach (live_list[i]) if (live_list[i] == s) idx = i;
      if (idx > 0) begin
        live_list.delete(idx);
        free_stack.push_front(s);
      end
    end
  endtask

  // Pick a live slot other than the head, or any slot when no other slot is live
  function automatic logic [SLOT_W-1:0] pick_live();
    if (live_list.size() > 1) return live_list[$urandom_range(1, live_list.size() - 1)];
    return SLOT_W'($urandom_range(0, SLOTS - 1));
  endfunction

  // Draw a random wait, with occasional runs of no waiting
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 50);
    return $urandom_range(0, 9);
  endfunction

  // Input driver: present the next beat after its gap, hold until taken
  int in_gap = 0;
  int in_calm = 0;
  always @(negedge clk) begin
    pool_op_t item;
    logic     next_valid;
    if (rst_n) begin
      next_valid = in_tvalid && !in_fired;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (op_queue.size() > 0) begin
          item = op_queue.pop_front();
          in_tdata   <= {1'b0, item.slot};
          in_tuser   <= item.op;
          next_valid = 1'b1;
          in_gap     = draw_wait(in_calm);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Output side: stall for a drawn number of cycles after each result beat
  int out_hold = 0;
  int out_calm = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fired) out_hold = draw_wait(out_calm);
      out_tready <= (out_hold == 0);
      if (out_hold > 0) out_hold--;
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin
    pool_res_t want;
    pool_res_t got;
    in_fired  <= rst_n && in_tvalid && in_tready;
    out_fired <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      due_results.push_back(pool_step(in_tuser, in_tdata[SLOT_W-1:0]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.slot   = out_tdata[SLOT_W-1:0];
      got.count  = out_tdata[SLOT_W+CNT_W-1:SLOT_W];
      got.has    = out_tuser[0];
      got.status = status_t'(out_tuser[2:1]);
      if (due_results.size() == 0) begin
        if (errors < 10) $display("unexpected result beat: slot %0d has %0d status %0d count %0d",
                                  got.slot, got.has, got.status, got.count);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (got.slot !== want.slot || got.has !== want.has ||
            got.status !== want.status || got.count !== want.count) begin
          if (errors < 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected slot %0d has %0d status %0d count %0d",
                     want.slot, want.has, want.status, want.count);
            $display("  actual   slot %0d has %0d status %0d count %0d",
                     got.slot, got.has, got.status, got.count);
          end
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    int               mode;
    int               n;
    logic [SLOT_W-1:0] walk[$];

    // Shadow reset: slot 0 is the head, free list pops 1, 2, 3 ...
    for (int i = 0; i < SLOTS; i++) begin
      prev_link[i] = 8'(i + 1);
      next_link[i] = LINK_NONE;
      in_use[i]    = 1'b0;
    end
    prev_link[SLOTS-1] = LINK_NONE;
    prev_link[0]       = LINK_NONE;
    in_use[0]          = 1'b1;
    free_head  = 8'd1;
    tail_slot  = 8'd0;
    live_count = 8'd1;
    live_list.push_back('0);
    for (int i = 1; i < SLOTS; i++) free_stack.push_back(SLOT_W'(i));

    // Directed: end of list, head release, free-slot release, spare opcode,
    // middle and tail release, follow of a freed slot, reuse of a freed slot
    plan(OP_FOLLOW, 7'd0);
    plan(OP_RELEASE, 7'd0);
    plan(OP_RELEASE, 7'd127);
    plan(OP_SPARE, 7'd85);
    plan(OP_ALLOC, 7'd0);
    plan(OP_ALLOC, 7'd127);
    plan(OP_ALLOC, 7'd42);
    plan(OP_FOLLOW, 7'd0);
    plan(OP_FOLLOW, 7'd3);
    plan(OP_RELEASE, 7'd2);
    plan(OP_FOLLOW, 7'd1);
    plan(OP_FOLLOW, 7'd2);
    plan(OP_RELEASE, 7'd2);
    plan(OP_RELEASE, 7'd3);
    plan(OP_ALLOC, 7'd0);
    plan(OP_RELEASE, 7'd1);
    plan(OP_FOLLOW, 7'd0);
    plan(OP_FOLLOW, 7'd127);
    plan(OP_SPARE, 7'd0);
    plan(OP_ALLOC, 7'd0);

    // Random: first overfill the pool, then mix fill, churn, walk, drain, noise
    mode = 0;
    while (planned < 1420) begin
      case (mode)
        0: begin
          n = (planned < 40) ? 140 : $urandom_range(1, 140);
          repeat (n) plan(OP_ALLOC, SLOT_W'($urandom));
        end
        1: begin
          repeat (40) begin
            n = $urandom_range(0, 99);
            if (n < 45) plan(OP_ALLOC, SLOT_W'($urandom));
            else if (n < 80) plan(OP_RELEASE, pick_live());
            else if (n < 92) plan(OP_FOLLOW, pick_live());
            else plan(OP_FOLLOW, SLOT_W'($urandom));
          end
        end
        2: begin
          walk = live_list;
          foreach (walk[i]) begin
            plan(OP_FOLLOW, walk[i]);
            if (i > 0 && $urandom_range(0, 4) == 0) begin
              plan(OP_RELEASE, walk[i]);
              plan(OP_FOLLOW, walk[i]);
            end
          end
        end
        3: begin
          n = $urandom_range(1, live_list.size());
          repeat (n) plan(OP_RELEASE, pick_live());
        end
        default: begin
          repeat (20) plan(OP_W'($urandom_range(0, 3)), SLOT_W'($urandom));
        end
      endcase
      mode = $urandom_range(0, 4);
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all beats sent, all results seen, then a short quiet spell
    @(posedge clk);
    while (op_queue.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
